/* src/assert_macros.svh */
// Assertion helpers included by the sequencer top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of aclk, held off while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks an implication at every rising edge of aclk, held off while aresetn is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/lcdmts_pkg.sv */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer package
// Mode codes, timing constants, STAT source bits and shared types.
// ----------------------------------------------------------------------------
package lcdmts_pkg;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [9:0] OAM_DOTS    = 10'd80;
    localparam logic [9:0] XFER_DOTS   = 10'd172;
    localparam logic [9:0] HBLANK_DOTS = 10'd204;
    localparam logic [9:0] LINE_DOTS   = 10'd456;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    localparam logic [7:0] SRC_HBLANK  = 8'h08;
    localparam logic [7:0] SRC_VBLANK  = 8'h10;
    localparam logic [7:0] SRC_OAM     = 8'h20;
    localparam logic [7:0] SRC_LYC     = 8'h40;
    localparam logic [7:0] SRC_MASK    = 8'h78;
    localparam logic [7:0] COINC_BIT   = 8'h04;
    localparam logic [7:0] MODE_MASK   = 8'hF8;

    localparam logic [7:0] STATUS_RESET = 8'h02;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] dots;
        logic [7:0] line;
        logic [7:0] status;
    } seq_state_t;

    typedef struct packed {
        logic vblank_irq;
        logic status_irq;
        logic render_line;
        logic frame_done;
    } seq_flags_t;

endpackage

/* src/lcdmts_step.sv */
// ----------------------------------------------------------------------------
// LCD mode timing step
// Advances the dot counter, line and mode by one tick and builds STAT.
// ----------------------------------------------------------------------------
module lcdmts_step (
    input  lcdmts_pkg::seq_state_t cur_state,
    input  logic [7:0]             dot_clocks,
    input  logic [7:0]             compare_line,
    output lcdmts_pkg::seq_state_t nxt_state,
    output lcdmts_pkg::seq_flags_t flags
);
    import lcdmts_pkg::*;

    logic [9:0] dot_sum;
    logic [7:0] line_inc;
    logic [7:0] src_bit;
    logic       src_fire;
    logic [7:0] status_src;
    logic [7:0] status_mode;

    // The counter stays below 456 between ticks, so the sum fits in 10 bits.
    assign dot_sum  = cur_state.dots + {2'b00, dot_clocks};
    assign line_inc = cur_state.line + 8'd1;

    always_comb begin
        nxt_state      = cur_state;
        nxt_state.dots = dot_sum;
        flags          = '0;
        src_bit        = '0;
        src_fire       = 1'b0;
        case (cur_state.mode)
            MODE_OAM: begin
                if (dot_sum >= OAM_DOTS) begin
                    nxt_state.dots = '0;
                    nxt_state.mode = MODE_XFER;
                end
            end
            MODE_XFER: begin
                if (dot_sum >= XFER_DOTS) begin
                    nxt_state.dots    = '0;
                    nxt_state.mode    = MODE_HBLANK;
                    src_bit           = SRC_HBLANK;
                    src_fire          = 1'b1;
                    flags.render_line = 1'b1;
                end
            end
            MODE_HBLANK: begin
                if (dot_sum >= HBLANK_DOTS) begin
                    nxt_state.dots = '0;
                    nxt_state.line = line_inc;
                    if (line_inc == VBLANK_LINE) begin
                        nxt_state.mode   = MODE_VBLANK;
                        src_bit          = SRC_VBLANK;
                        src_fire         = 1'b1;
                        flags.vblank_irq = 1'b1;
                        flags.frame_done = 1'b1;
                    end else begin
                        nxt_state.mode = MODE_OAM;
                    end
                end
            end
            default: begin
                if (dot_sum >= LINE_DOTS) begin
                    nxt_state.dots = '0;
                    nxt_state.line = line_inc;
                    if (line_inc > LAST_LINE) begin
                        nxt_state.mode = MODE_OAM;
                        nxt_state.line = '0;
                        src_bit        = SRC_OAM;
                        src_fire       = 1'b1;
                    end
                end
            end
        endcase

        status_src  = src_fire ? ((cur_state.status & ~SRC_MASK) | src_bit)
                               : cur_state.status;
        status_mode = (status_src & MODE_MASK) | {6'd0, nxt_state.mode};

        // Coincidence comes last and replaces any source set on this tick.
        if (nxt_state.line == compare_line) begin
            nxt_state.status = ((status_mode | COINC_BIT) & ~SRC_MASK) | SRC_LYC;
            flags.status_irq = 1'b1;
        end else begin
            nxt_state.status = status_mode;
            flags.status_irq = src_fire;
        end
    end

endmodule

/* src/lcd_mode_timing_sequencer_top.sv */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer
// A transfer accepted into the input register moves to the result register once that one is free or drains.
// Throughput: one tick per cycle while m_ready stays high; the state update is a single add and compare.
// An input register and a result register decouple the two channels.
// Reset (synchronous, active low): OAM search, line 0, counter 0, STAT 0x02,
// compare line 0, both channels empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_mode_timing_sequencer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_dot_clocks,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_lcd_mode,
    output logic [7:0] m_line_number,
    output logic [7:0] m_status_byte,
    output logic       m_vblank_irq,
    output logic       m_status_irq,
    output logic       m_render_line,
    output logic       m_frame_done
);
    import lcdmts_pkg::*;

    logic       compare_line_reg;
    logic [7:0] cmp_line_reg;
    logic       in_valid_reg;
    logic [7:0] in_dots_reg;
    logic       out_valid_reg;
    logic       advance;
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_flags_t flags_next;
    seq_state_t out_state_reg;
    seq_flags_t out_flags_reg;

    // An item moves into the result register when that register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    lcdmts_step u_step (
        .cur_state    (state_reg),
        .dot_clocks   (in_dots_reg),
        .compare_line (cmp_line_reg),
        .nxt_state    (state_next),
        .flags        (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_line_reg     <= '0;
            compare_line_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            cmp_line_reg     <= cfg_wr_data;
            compare_line_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_OAM, dots: '0, line: '0, status: STATUS_RESET};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_dots_reg <= s_dot_clocks;
        end
        if (advance) begin
            out_state_reg <= state_next;
            out_flags_reg <= flags_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_lcd_mode    = out_state_reg.mode;
    assign m_line_number = out_state_reg.line;
    assign m_status_byte = out_state_reg.status;
    assign m_vblank_irq  = out_flags_reg.vblank_irq;
    assign m_status_irq  = out_flags_reg.status_irq;
    assign m_render_line = out_flags_reg.render_line;
    assign m_frame_done  = out_flags_reg.frame_done;

    // The compare line only ever changes through a configuration write.
    `ASSERT_IMPLY(a_cmp_written, !compare_line_reg, cmp_line_reg == 8'd0, "compare line changed without a write")
    `ASSERT_CLK(a_dots_range, state_reg.dots < LINE_DOTS, "dot counter passed a full line")
    `ASSERT_IMPLY(a_line_mode, state_reg.mode != MODE_VBLANK, state_reg.line < VBLANK_LINE, "visible mode outside visible lines")
    `ASSERT_IMPLY(a_stat_mode, out_valid_reg, m_status_byte[1:0] == m_lcd_mode, "STAT mode bits differ from mode")
    `ASSERT_IMPLY(a_vblank_entry, out_valid_reg && m_vblank_irq, m_status_irq && m_frame_done && (m_lcd_mode == MODE_VBLANK), "vblank entry pulses inconsistent")

endmodule
